// File: hdl/ptts_pkg.sv
// Shared command codes, status codes, reset tick length and table entry type of the task scheduler.
`default_nettype none

package ptts_pkg;

  // Command codes carried by an input item
  localparam logic [2:0] CMD_ADD      = 3'd0;
  localparam logic [2:0] CMD_TICK     = 3'd1;
  localparam logic [2:0] CMD_DISPATCH = 3'd2;
  localparam logic [2:0] CMD_DELETE   = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;

  // Status codes of a result item
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  // Tick length after reset, in ms
  localparam logic [9:0] TICK_LEN_RESET = 10'd10;

  // One row of the task table
  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] delay_left;
    logic [31:0] period_ticks;
    logic [7:0]  pending_runs;
  } entry_t;

endpackage

`default_nettype wire

// File: hdl/periodic_task_table_scheduler.sv
// Periodic task table scheduler: packed task table walked by a small sequencer.
//
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_ready_o   command, task_handle, delay_ms, period_ms,
//                                                 slot_to_remove
//  out       output     out_valid_o / out_ready_i status, run_valid, run_handle, slot,
//                                                 tasks_held, last
//  cfg       input      cfg_we_i (no wait)        cfg_wdata_i = tick length in ms
//
// Add runs two 32-bit divisions by the tick length through one shared restoring divider
// that retires two quotient bits per cycle. Tick and dispatch pass each table entry
// through a read state and an update state (one read, one update per entry through the
// table memory, which has one write port and one read port); delete does the same for
// each entry shifted.
// in_ready_o is high only while the sequencer is idle; a result waiting in the output
// register stalls the sequencer only when a further result must be pushed.
// Reset clears the task count and restores the tick length to 10 ms; the table itself
// needs no clearing since entries at or above the count are never read.
`default_nettype none

module periodic_task_table_scheduler
  import ptts_pkg::*;
#(
  parameter int MAX_TASKS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [9:0]  cfg_wdata_i,
  // input items
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [15:0] task_handle_i,
  input  wire logic [31:0] delay_ms_i,
  input  wire logic [31:0] period_ms_i,
  input  wire logic [7:0]  slot_to_remove_i,
  // result items
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [1:0]  status_o,
  output      logic        run_valid_o,
  output      logic [15:0] run_handle_o,
  output      logic [5:0]  slot_o,
  output      logic [6:0]  tasks_held_o,
  output      logic        last_o
);

  localparam int IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW   = $clog2(MAX_TASKS + 1);
  localparam int CMPW = 9;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // One restoring division step: returns {new remainder, quotient bit}
  function automatic logic [10:0] div_step(input logic [9:0] rem, input logic nbit,
                                           input logic [9:0] dvs);
    logic [10:0] t;
    logic [10:0] r;
    t = {rem, nbit};
    if (t >= {1'b0, dvs}) begin
      r = t - {1'b0, dvs};
      div_step = {r[9:0], 1'b1};
    end else begin
      div_step = {t[9:0], 1'b0};
    end
  endfunction

  logic [2:0]    state_q, state_d;
  logic [9:0]    tick_len_q;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [2:0]    cmd_q, cmd_d;
  logic [15:0]   handle_q, handle_d;
  logic [31:0]   dly_q, dly_d;
  logic [31:0]   per_q, per_d;
  logic [31:0]   div_q, div_d;
  logic [9:0]    rem_q, rem_d;
  logic [3:0]    div_cnt_q, div_cnt_d;
  logic          div_pass_q, div_pass_d;
  // held result, pushed out once it is known whether it is the final one
  logic [1:0]    res_status_q, res_status_d;
  logic          res_valid_q, res_valid_d;
  logic [15:0]   res_handle_q, res_handle_d;
  logic [5:0]    res_slot_q, res_slot_d;
  // output register
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q, out_status_d;
  logic          out_run_q, out_run_d;
  logic [15:0]   out_handle_q, out_handle_d;
  logic [5:0]    out_slot_q, out_slot_d;
  logic [6:0]    out_held_q, out_held_d;
  logic          out_last_q, out_last_d;

  // table memory
  entry_t        entry_mem [MAX_TASKS];
  entry_t        rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_wdata;

  logic          out_free;
  logic          out_load;
  logic          out_last;
  logic [9:0]    divisor;
  logic [10:0]   step1, step2;
  logic [CMPW-1:0] idx_ext, cnt_ext, rm_ext;
  logic          last_step;

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_free     = !out_valid_q || out_ready_i;
  assign divisor      = (tick_len_q == 10'd0) ? 10'd1 : tick_len_q;
  assign step1        = div_step(rem_q, div_q[31], divisor);
  assign step2        = div_step(step1[10:1], div_q[30], divisor);
  assign idx_ext      = CMPW'(idx_q);
  assign cnt_ext      = CMPW'(count_q);
  assign rm_ext       = CMPW'(slot_to_remove_i);
  // delete reads one entry ahead, so it ends one step earlier
  assign last_step    = (cmd_q == CMD_DELETE) ? (idx_ext + CMPW'(2) >= cnt_ext)
                                              : (idx_ext + CMPW'(1) >= cnt_ext);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    cmd_d        = cmd_q;
    handle_d     = handle_q;
    dly_d        = dly_q;
    per_d        = per_q;
    div_d        = div_q;
    rem_d        = rem_q;
    div_cnt_d    = div_cnt_q;
    div_pass_d   = div_pass_q;
    res_status_d = res_status_q;
    res_valid_d  = res_valid_q;
    res_handle_d = res_handle_q;
    res_slot_d   = res_slot_q;
    out_load     = 1'b0;
    out_last     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = rd_q;
    mem_raddr    = (cmd_q == CMD_DELETE) ? IW'(idx_ext + CMPW'(1)) : idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = command_i;
          handle_d     = task_handle_i;
          per_d        = period_ms_i;
          idx_d        = '0;
          res_status_d = ST_OK;
          res_valid_d  = 1'b0;
          res_handle_d = '0;
          res_slot_d   = '0;
          state_d      = S_FIN;
          priority case (command_i)
            CMD_ADD: begin
              if (count_q >= CW'(MAX_TASKS)) begin
                res_status_d = ST_FULL;
              end else begin
                div_d      = delay_ms_i;
                rem_d      = '0;
                div_cnt_d  = '0;
                div_pass_d = 1'b0;
                state_d    = S_DIV;
              end
            end
            CMD_TICK, CMD_DISPATCH: begin
              if (count_q != '0) state_d = S_RD;
            end
            CMD_DELETE: begin
              if (rm_ext >= cnt_ext) begin
                res_status_d = ST_BAD_INDEX;
              end else begin
                res_slot_d = slot_to_remove_i[5:0];
                idx_d      = IW'(slot_to_remove_i);
                if (rm_ext + CMPW'(1) >= cnt_ext) begin
                  count_d = count_q - CW'(1);
                end else begin
                  state_d = S_RD;
                end
              end
            end
            CMD_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end

      // two quotient bits per cycle; pass 0 is the delay, pass 1 the period
      S_DIV: begin
        div_d     = {div_q[29:0], step1[0], step2[0]};
        rem_d     = step2[10:1];
        div_cnt_d = div_cnt_q + 4'd1;
        if (div_cnt_q == 4'd15) begin
          if (!div_pass_q) begin
            dly_d      = {div_q[29:0], step1[0], step2[0]};
            div_d      = per_q;
            rem_d      = '0;
            div_pass_d = 1'b1;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = IW'(count_q);
            mem_wdata  = '{handle: handle_q, delay_left: dly_q,
                           period_ticks: {div_q[29:0], step1[0], step2[0]},
                           pending_runs: 8'd0};
            res_slot_d = 6'(count_q);
            count_d    = count_q + CW'(1);
            state_d    = S_FIN;
          end
        end
      end

      S_RD: state_d = S_UPD;

      S_UPD: begin
        logic advance;
        advance = 1'b1;
        priority case (cmd_q)
          CMD_TICK: begin
            mem_we = 1'b1;
            if (rd_q.delay_left != '0) begin
              mem_wdata.delay_left = rd_q.delay_left - 32'd1;
            end else begin
              mem_wdata.delay_left = rd_q.period_ticks;
              if (rd_q.pending_runs != 8'hFF) begin
                mem_wdata.pending_runs = rd_q.pending_runs + 8'd1;
              end
            end
          end
          CMD_DISPATCH: begin
            if (rd_q.pending_runs != 8'd0) begin
              if (res_valid_q && !out_free) begin
                advance = 1'b0;
              end else begin
                mem_we                 = 1'b1;
                mem_wdata.pending_runs = rd_q.pending_runs - 8'd1;
                out_load               = res_valid_q;
                res_valid_d            = 1'b1;
                res_handle_d           = rd_q.handle;
                res_slot_d             = 6'(idx_q);
              end
            end
          end
          default: begin
            // delete: move the next entry down one slot
            mem_we = 1'b1;
          end
        endcase
        if (advance) begin
          if (last_step) begin
            if (cmd_q == CMD_DELETE) count_d = count_q - CW'(1);
            state_d = S_FIN;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_RD;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_last = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output register loads the held result
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_run_d    = out_run_q;
    out_handle_d = out_handle_q;
    out_slot_d   = out_slot_q;
    out_held_d   = out_held_q;
    out_last_d   = out_last_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_run_d    = res_valid_q;
      out_handle_d = res_handle_q;
      out_slot_d   = res_slot_q;
      out_held_d   = 7'(count_q);
      out_last_d   = out_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      tick_len_q  <= TICK_LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) tick_len_q <= cfg_wdata_i;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    cmd_q        <= cmd_d;
    handle_q     <= handle_d;
    dly_q        <= dly_d;
    per_q        <= per_d;
    div_q        <= div_d;
    rem_q        <= rem_d;
    div_cnt_q    <= div_cnt_d;
    div_pass_q   <= div_pass_d;
    res_status_q <= res_status_d;
    res_valid_q  <= res_valid_d;
    res_handle_q <= res_handle_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_run_q    <= out_run_d;
    out_handle_q <= out_handle_d;
    out_slot_q   <= out_slot_d;
    out_held_q   <= out_held_d;
    out_last_q   <= out_last_d;
  end

  // Task table: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
    rd_q <= entry_mem[mem_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign run_valid_o  = out_run_q;
  assign run_handle_o = out_handle_q;
  assign slot_o       = out_slot_q;
  assign tasks_held_o = out_held_q;
  assign last_o       = out_last_q;

endmodule

`default_nettype wire
